FILE: rtl/jts_pkg.sv
// shared types and constants for the joint target stepper
`default_nettype none

package jts_pkg;

    localparam int MAX_JOINTS = 6;
    localparam int FRAC_BITS  = 12;
    localparam int POS_W      = 16;
    localparam int STEP_W     = 17;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;
    localparam int IDX_W      = 3;
    localparam int PROD_W     = 33;
    localparam int ACC_W      = 34;

    localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd4096;
    localparam logic [LIM_W-1:0]  LIMIT_RESET = 15'd3217;

    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [STEP_W-1:0] step_t;
    typedef logic [POS_W-1:0]         mag_t;

    typedef enum logic
    {
        REG_GAIN  = 1'b0,
        REG_LIMIT = 1'b1
    } cfg_reg_t;

    // per-tick controls broadcast to every joint lane
    typedef struct packed
    {
        logic load;
        logic take_new;
        logic commit;
    } jts_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/jts_joint.sv
// one joint lane: step/velocity stage, position update stage and per-joint state
`default_nettype none

module jts_joint
    import jts_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire jts_ctrl_t         ctrl,
    input  wire pos_t              target,
    input  wire logic [GAIN_W-1:0] gain,
    input  wire logic [LIM_W-1:0]  limit,
    output pos_t                   pos_next,
    output pos_t                   vel,
    output mag_t                   diff_mag,
    output mag_t                   step_mag
);

    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] POS_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] POS_MIN = -ACC_W'(32768);

    pos_t  pos_reg;
    pos_t  held_reg;
    step_t step_reg;
    pos_t  vel_reg;

    step_t                     step_new;
    logic signed [STEP_W:0]    dbl;
    logic signed [STEP_W:0]    lim_s;
    logic signed [STEP_W:0]    vel_sel;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   rnd;
    logic signed [ACC_W-1:0]   delta;
    logic signed [ACC_W-1:0]   sum;
    pos_t                      sat;
    step_t                     diff;
    step_t                     diff_abs;
    step_t                     step_abs;

    // stage one: new step and clamped velocity
    assign step_new = ctrl.take_new ? (STEP_W'(target) - STEP_W'(pos_reg)) : step_reg;
    assign dbl      = $signed({step_new, 1'b0});
    assign lim_s    = $signed({3'b000, limit});

    always_comb
    begin
        if (dbl > lim_s)
            vel_sel = lim_s;
        else if (dbl < -lim_s)
            vel_sel = -lim_s;
        else
            vel_sel = dbl;
    end

    // stage two: scaled move, round half up, saturate, stop at target
    assign prod  = PROD_W'(vel_reg) * $signed({1'b0, gain});
    assign rnd   = ACC_W'(prod) + HALF;
    assign delta = rnd >>> FRAC_BITS;
    assign sum   = ACC_W'(pos_reg) + delta;

    always_comb
    begin
        if (sum > POS_MAX)
            sat = pos_t'(POS_MAX);
        else if (sum < POS_MIN)
            sat = pos_t'(POS_MIN);
        else
            sat = pos_t'(sum);

        if (!vel_reg[POS_W-1] && (sat > held_reg))
            pos_next = held_reg;
        else if (vel_reg[POS_W-1] && (sat < held_reg))
            pos_next = held_reg;
        else
            pos_next = sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            held_reg <= '0;
            step_reg <= '0;
        end
        else
        begin
            if (ctrl.load && ctrl.take_new)
            begin
                held_reg <= target;
                step_reg <= step_new;
            end
            if (ctrl.commit)
                pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            vel_reg <= pos_t'(vel_sel);
    end

    assign vel = vel_reg;

    assign diff     = STEP_W'(held_reg) - STEP_W'(pos_reg);
    assign diff_abs = diff[STEP_W-1] ? -diff : diff;
    assign step_abs = step_reg[STEP_W-1] ? -step_reg : step_reg;
    assign diff_mag = diff_abs[POS_W-1:0];
    assign step_mag = step_abs[POS_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/jts_metric.sv
// distance-to-target versus step-size test that gates new targets
`default_nettype none

module jts_metric
    import jts_pkg::*;
#(
    parameter int JOINTS = 6
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire mag_t diff_mag [JOINTS],
    input  wire mag_t step_mag [JOINTS],
    output logic      far
);

    logic   far_reg;
    logic   far_next;
    mag_t   dmax;
    mag_t   smax;
    logic [POS_W+1:0] d3;
    logic [POS_W+1:0] s2;

    always_comb
    begin
        dmax = '0;
        smax = '0;
        for (int j = 0; j < JOINTS; j++)
        begin
            if (diff_mag[j] > dmax)
                dmax = diff_mag[j];
            if (step_mag[j] > smax)
                smax = step_mag[j];
        end
        d3       = {2'b00, dmax} + {1'b0, dmax, 1'b0};
        s2       = {1'b0, smax, 1'b0};
        far_next = d3 > s2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            far_reg <= 1'b0;
        else
            far_reg <= far_next;
    end

    assign far = far_reg;

endmodule

`default_nettype wire

FILE: rtl/jts_out.sv
// result buffer, shifts out one joint per beat
`default_nettype none

module jts_out
    import jts_pkg::*;
#(
    parameter int JOINTS = 6
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire pos_t              pos_in [JOINTS],
    input  wire pos_t              vel_in [JOINTS],
    output logic                   free,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [2*POS_W-1:0]     m_tdata,
    output logic [IDX_W-1:0]       m_tuser,
    output logic                   m_tlast
);

    logic             valid_reg;
    logic [IDX_W-1:0] idx_reg;
    pos_t             pos_buf [JOINTS];
    pos_t             vel_buf [JOINTS];
    logic             beat;
    logic             last;

    assign last = idx_reg == IDX_W'(JOINTS - 1);
    assign beat = valid_reg && m_tready;
    assign free = !valid_reg || (m_tready && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (beat)
        begin
            valid_reg <= !last;
            idx_reg   <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pos_buf <= pos_in;
            vel_buf <= vel_in;
        end
        else if (beat)
        begin
            for (int j = 0; j < JOINTS - 1; j++)
            begin
                pos_buf[j] <= pos_buf[j+1];
                vel_buf[j] <= vel_buf[j+1];
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {vel_buf[0], pos_buf[0]};
    assign m_tuser  = idx_reg;
    assign m_tlast  = valid_reg && last;

endmodule

`default_nettype wire

FILE: rtl/joint_target_stepper.sv
// joint target stepper top level
//
//  channel  dir  handshake          payload
//  cfg      in   cfg_wen            cfg_addr (0 gain, 1 limit), cfg_data
//  s_*      in   s_tvalid/s_tready  s_tdata targets, s_tuser target_present
//  m_*      out  m_tvalid/m_tready  m_tdata position/velocity, m_tuser index, m_tlast
//
// a tick with a target (or with one held) gives JOINTS beats, one per joint;
// the result buffer drains one beat per cycle while m_tready is high; the first
// beat passes the input register, the stage-one registers and the result buffer.
// a tick with no target while none is held is consumed with no beats.
// the next tick is taken into the input register while results still drain.
// reset clears positions, held target and steps; registers return to defaults.
`default_nettype none

module joint_target_stepper
    import jts_pkg::*;
#(
    parameter int JOINTS = 6
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wen,
    input  wire logic [0:0]                  cfg_addr,
    input  wire logic [GAIN_W-1:0]           cfg_data,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [MAX_JOINTS*POS_W-1:0] s_tdata,  // target_0 .. target_5
    input  wire logic [0:0]                  s_tuser,  // target_present
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [2*POS_W-1:0]               m_tdata,  // joint_position, joint_velocity
    output logic [IDX_W-1:0]                 m_tuser,  // joint_index
    output logic                             m_tlast   // last_of_run
);

    logic [GAIN_W-1:0] gain_reg;
    logic [LIM_W-1:0]  limit_reg;
    logic              in_valid_reg;
    logic              present_reg;
    pos_t              tgt_reg [JOINTS];
    logic              held_reg;
    logic              far_valid_reg;
    logic              met_pending_reg;
    logic              s1_valid_reg;

    logic      s1_fire;
    logic      s2_fire;
    logic      out_free;
    logic      far;
    logic      in_beat;
    jts_ctrl_t ctrl;
    pos_t      pos_next [JOINTS];
    pos_t      vel      [JOINTS];
    mag_t      diff_mag [JOINTS];
    mag_t      step_mag [JOINTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_GAIN:  gain_reg  <= cfg_data;
                REG_LIMIT: limit_reg <= cfg_data[LIM_W-1:0];
            endcase
        end
    end

    // decision waits for the distance test of the state left by the last tick
    assign s1_fire  = in_valid_reg && far_valid_reg;
    assign s2_fire  = s1_valid_reg && out_free;
    assign s_tready = !in_valid_reg || s1_fire;
    assign in_beat  = s_tvalid && s_tready;

    always_comb
    begin
        ctrl          = '0;
        ctrl.load     = s1_fire && (held_reg || present_reg);
        ctrl.take_new = present_reg && (!held_reg || !far);
        ctrl.commit   = s2_fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            held_reg        <= 1'b0;
            far_valid_reg   <= 1'b1;
            met_pending_reg <= 1'b0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_beat)
                in_valid_reg <= 1'b1;
            else if (s1_fire)
                in_valid_reg <= 1'b0;

            if (ctrl.load)
                held_reg <= 1'b1;

            if (ctrl.load)
                s1_valid_reg <= 1'b1;
            else if (s2_fire)
                s1_valid_reg <= 1'b0;

            met_pending_reg <= s2_fire;

            if (ctrl.load)
                far_valid_reg <= 1'b0;
            else if (met_pending_reg)
                far_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            present_reg <= s_tuser[0];
            for (int j = 0; j < JOINTS; j++)
                tgt_reg[j] <= s_tdata[j*POS_W +: POS_W];
        end
    end

    for (genvar g = 0; g < JOINTS; g++)
    begin : g_joint
        jts_joint u_joint
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .target   (tgt_reg[g]),
            .gain     (gain_reg),
            .limit    (limit_reg),
            .pos_next (pos_next[g]),
            .vel      (vel[g]),
            .diff_mag (diff_mag[g]),
            .step_mag (step_mag[g])
        );
    end

    jts_metric #(.JOINTS(JOINTS)) u_metric
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .diff_mag (diff_mag),
        .step_mag (step_mag),
        .far      (far)
    );

    jts_out #(.JOINTS(JOINTS)) u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s2_fire),
        .pos_in   (pos_next),
        .vel_in   (vel),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/jts_checker.sv
// port-level checks on the result stream, bound to the top level
`default_nettype none

module jts_checker
    import jts_pkg::*;
#(
    parameter int JOINTS = 6
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [2*POS_W-1:0]  m_tdata,
    input  wire logic [IDX_W-1:0]    m_tuser,
    input  wire logic                m_tlast
);

    // tlast marks exactly the final joint
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == IDX_W'(JOINTS - 1))))
        else $error("tlast does not match final joint index");

    // a run continues without gaps, joint index counting up
    a_run_next: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tuser == IDX_W'($past(m_tuser) + IDX_W'(1)))))
        else $error("run broken or joint index skipped");

    // a new run starts at joint zero
    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || (m_tuser == '0)))
        else $error("run does not start at joint zero");

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled output beat changed");

endmodule

bind joint_target_stepper jts_checker #(.JOINTS(JOINTS)) u_jts_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: bench/testbench.sv
// self-checking testbench for the joint target stepper with a tick-level predictor
`timescale 1ns / 100ps

module testbench;
    import jts_pkg::*;

    localparam int JOINTS      = MAX_JOINTS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed
    {
        logic                   present;
        pos_t [MAX_JOINTS-1:0]  tgt;
    } tick_t;

    typedef struct packed
    {
        logic [IDX_W-1:0] idx;
        pos_t             pos;
        pos_t             vel;
        logic             last;
    } beat_t;

    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        cfg_wen  = 1'b0;
    logic [0:0]                  cfg_addr = REG_GAIN;
    logic [GAIN_W-1:0]           cfg_data = '0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [MAX_JOINTS*POS_W-1:0] s_tdata  = '0;
    logic [0:0]                  s_tuser  = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [2*POS_W-1:0]          m_tdata;
    logic [IDX_W-1:0]            m_tuser;
    logic                        m_tlast;

    // predictor state
    int    pos_m  [JOINTS];
    int    held_m [JOINTS];
    int    step_m [JOINTS];
    bit    holding = 1'b0;
    int    gain_m  = int'(GAIN_RESET);
    int    lim_m   = int'(LIMIT_RESET);

    tick_t ticks_pending [$];
    beat_t joint_beats_due [$];
    tick_t cur_tick;

    int    send_idle = 11;
    int    recv_idle = 47;
    bit    hold_req  = 1'b0;
    logic  rx_hold   = 1'b0;

    int    mismatches   = 0;
    int    ticks_taken  = 0;
    int    target_ticks = 0;
    int    beats_seen   = 0;
    int    settings     = 0;
    int unsigned cycle_count = 0;

    joint_target_stepper #(.JOINTS(JOINTS)) u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // target_0 .. target_5
        .s_tuser  (s_tuser),   // target_present
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // joint_position, joint_velocity
        .m_tuser  (m_tuser),   // joint_index
        .m_tlast  (m_tlast)    // last_of_run
    );

    always #5 clk = ~clk;

    initial
    begin
        for (int j = 0; j < JOINTS; j++)
        begin
            pos_m[j]  = 0;
            held_m[j] = 0;
            step_m[j] = 0;
        end
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatches < 30)
            $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // advance the joints by one servo tick and queue the beats it gives
    task automatic step_joints(input tick_t t);
        int    dmax;
        int    smax;
        int    a;
        int    v;
        int    goal [JOINTS];
        longint np;
        bit    take;
        beat_t b;
        dmax = 0;
        smax = 0;
        if (!holding && !t.present)
            return;
        for (int j = 0; j < JOINTS; j++)
        begin
            a = held_m[j] - pos_m[j];
            if (a < 0) a = -a;
            if (a > dmax) dmax = a;
            a = step_m[j];
            if (a < 0) a = -a;
            if (a > smax) smax = a;
        end
        // still far from the held target: refuse the new one
        take = !holding || (t.present && !(3 * dmax > 2 * smax));
        for (int j = 0; j < JOINTS; j++)
        begin
            if (take)
            begin
                goal[j]   = int'($signed(t.tgt[j]));
                step_m[j] = goal[j] - pos_m[j];
            end
            else
                goal[j] = held_m[j];
        end
        for (int j = 0; j < JOINTS; j++)
        begin
            v = 2 * step_m[j];
            if (v > lim_m)
                v = lim_m;
            else if (v < -lim_m)
                v = -lim_m;
            // round to nearest, ties toward plus infinity
            np = longint'(pos_m[j])
               + ((longint'(v) * longint'(gain_m) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
            if (np > 32767)
                np = 32767;
            else if (np < -32768)
                np = -32768;
            // no overshoot past the target
            if (v >= 0 && np > goal[j])
                np = goal[j];
            else if (v < 0 && np < goal[j])
                np = goal[j];
            pos_m[j]  = int'(np);
            held_m[j] = goal[j];
            b.idx  = IDX_W'(j);
            b.pos  = pos_m[j][POS_W-1:0];
            b.vel  = v[POS_W-1:0];
            b.last = (j == JOINTS - 1);
            joint_beats_due.push_back(b);
        end
        holding = 1'b1;
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                step_joints(cur_tick);
                ticks_taken++;
                if (cur_tick.present)
                    target_ticks++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (ticks_pending.size() > 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    cur_tick = ticks_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_tick.tgt;
                    s_tuser  <= cur_tick.present;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : rx_side
        beat_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                beats_seen++;
                if (joint_beats_due.size() == 0)
                    flag_mismatch("beat with none due, joint", int'(m_tuser), -1);
                else
                begin
                    want = joint_beats_due.pop_front();
                    if (m_tuser != want.idx)
                        flag_mismatch("joint_index", int'(m_tuser), int'(want.idx));
                    if (m_tdata[POS_W-1:0] != want.pos)
                        flag_mismatch("joint_position", int'($signed(m_tdata[POS_W-1:0])),
                                      int'(want.pos));
                    if (m_tdata[2*POS_W-1:POS_W] != want.vel)
                        flag_mismatch("joint_velocity",
                                      int'($signed(m_tdata[2*POS_W-1:POS_W])), int'(want.vel));
                    if (m_tlast != want.last)
                        flag_mismatch("last_of_run", int'(m_tlast), int'(want.last));
                end
            end
            m_tready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still due", cycle_count,
                     joint_beats_due.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic pos_t rand_angle();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'sh7FFF;
        if (r == 1)
            return 16'sh8000;
        if (r < 6)
            return pos_t'($urandom);
        return pos_t'($urandom_range(0, 4095) - 2048);
    endfunction

    task automatic queue_tick(input bit present, input pos_t even_tgt, input pos_t odd_tgt);
        tick_t t;
        t.present = present;
        for (int j = 0; j < MAX_JOINTS; j++)
            t.tgt[j] = (j % 2 == 0) ? even_tgt : odd_tgt;
        ticks_pending.push_back(t);
    endtask

    task automatic drain();
        while (!(ticks_pending.size() == 0 && !s_tvalid && joint_beats_due.size() == 0))
            @(negedge clk);
        // a tick with no target may still sit in the pipe
        repeat (8) @(posedge clk);
    endtask

    task automatic write_regs(input int gain, input int limit);
        @(posedge clk);
        cfg_wen  <= 1'b1;
        cfg_addr <= REG_GAIN;
        cfg_data <= GAIN_W'(gain);
        gain_m    = gain;
        @(posedge clk);
        cfg_addr <= REG_LIMIT;
        cfg_data <= GAIN_W'(limit);
        lim_m     = limit;
        @(posedge clk);
        cfg_wen  <= 1'b0;
        settings++;
    endtask

    task automatic run_phase(input int count, input int tx_idle, input int rx_idle);
        tick_t t;
        @(negedge clk);
        send_idle = tx_idle;
        recv_idle = rx_idle;
        for (int n = 0; n < count; n++)
        begin
            t.present = ($urandom_range(0, 99) < 75);
            for (int j = 0; j < MAX_JOINTS; j++)
                t.tgt[j] = rand_angle();
            ticks_pending.push_back(t);
        end
        drain();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: no target yet, extremes, refusal while far, snapping
        queue_tick(1'b0, 16'sh1234, -16'sh1234);
        queue_tick(1'b0, 16'sh7FFF, 16'sh8000);
        queue_tick(1'b1, 16'sh7FFF, 16'sh8000);
        queue_tick(1'b1, 16'sh0000, 16'sh0000);
        queue_tick(1'b1, 16'sh0100, -16'sh0100);
        repeat (4) queue_tick(1'b0, 16'sh0000, 16'sh0000);
        queue_tick(1'b1, -16'sh0001, 16'sh0001);
        queue_tick(1'b1, -16'sh0001, 16'sh0001);
        queue_tick(1'b1, 16'sh5555, 16'shAAAA);
        repeat (3) queue_tick(1'b0, 16'shFFFF, 16'shFFFF);
        queue_tick(1'b1, 16'sh0064, -16'sh0064);
        queue_tick(1'b1, 16'sh0000, 16'sh0000);
        queue_tick(1'b0, 16'sh0000, 16'sh0000);
        queue_tick(1'b1, 16'sh8000, 16'sh7FFF);
        repeat (3) queue_tick(1'b0, 16'sh0000, 16'sh0000);
        drain();

        write_regs(32'hFFFF, 32'h7FFF);
        run_phase(45, 11, 47);
        write_regs(0, 0);
        run_phase(20, 47, 11);
        write_regs($urandom_range(0, 65535), $urandom_range(0, 32767));
        run_phase(55, 47, 11);
        write_regs(int'(GAIN_RESET), int'(LIMIT_RESET));
        hold_req = 1'b1;
        run_phase(30, 0, 0);
        write_regs($urandom_range(0, 65535), $urandom_range(1, 32767));
        run_phase(55, 0, 0);

        repeat (10) @(posedge clk);
        $display("ran %0d servo ticks (%0d with a target) over %0d register settings",
                 ticks_taken, target_ticks, settings);
        $display("checked %0d joint beats, %0d mismatches", beats_seen, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
